[rtl/irc_tok_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_tok_pkg
// Shared types, codes and the command name table for the IRC line tokenizer.
// ----------------------------------------------------------------------------
package irc_tok_pkg;

    // Middle parameter at which the rest of the middle part is taken verbatim
    localparam int MAX_MIDDLE_PARAMS = 19;
    localparam int NAME_COUNT        = 19;
    localparam int RESULTS_MAX       = 3;

    // Bytes with a special meaning
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_COLON = 8'h3A;

    typedef enum logic [2:0] {
        KIND_ORIGIN  = 3'd0,
        KIND_COMMAND = 3'd1,
        KIND_MIDDLE  = 3'd2,
        KIND_TRAIL   = 3'd3,
        KIND_SUMMARY = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_GOOD   = 2'd0,
        STATUS_BLANK  = 2'd1,
        STATUS_NO_CMD = 2'd2
    } status_t;

    // One result transaction
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [4:0]  param_index;
        logic        token_first;
        logic [4:0]  command_code;
        logic [4:0]  param_total;
        status_t     line_status;
        logic        run_last;
    } res_t;

    // All results caused by one input byte, in order
    typedef struct packed {
        logic [1:0]        count;
        res_t [RESULTS_MAX-1:0] slot;
    } bundle_t;

    // Command names, left aligned, zero padded to eight characters
    localparam logic [63:0] NAME_TAB [NAME_COUNT] = '{
        {"PING",    32'h0}, {"PONG",    32'h0}, {"PRIVMSG",  8'h0},
        {"SJOIN",   24'h0}, {"PART",    32'h0}, {"NICK",    32'h0},
        {"QUIT",    32'h0}, {"MODE",    32'h0}, {"KICK",    32'h0},
        {"KILL",    32'h0}, {"SQUIT",   24'h0}, {"SERVER",  16'h0},
        {"STATS",   24'h0}, {"ADMIN",   24'h0}, {"VERSION",  8'h0},
        {"INFO",    32'h0}, {"JOIN",    32'h0}, {"PASS",    32'h0},
        {"ERROR",   24'h0}
    };

    // Character at a position of a name; zero past its end
    function automatic logic [7:0] name_char(int k, logic [2:0] pos);
        logic [63:0] w;
        logic [5:0]  sh;
        w  = NAME_TAB[k];
        sh = {~pos, 3'b000};
        return w[sh +: 8];
    endfunction

    // Byte result with the summary fields cleared
    function automatic res_t tok_res(kind_t kind, logic [7:0] data, logic [4:0] idx,
                                     logic first);
        res_t r;
        r             = '0;
        r.kind        = kind;
        r.data_byte   = data;
        r.param_index = idx;
        r.token_first = first;
        return r;
    endfunction

endpackage

[rtl/irc_tok_parse.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_tok_parse
// Line state and the single-pass step: classifies one byte, updates the
// command match and parameter count, and builds the result bundle.
// ----------------------------------------------------------------------------
module irc_tok_parse (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  logic [7:0]           byte_in,
    input  logic                 line_end,
    output irc_tok_pkg::bundle_t bundle
);

    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_ORIGIN = 4'd1,
        PH_CMD_A  = 4'd2,
        PH_CMD_B  = 4'd3,
        PH_MSG    = 4'd4,
        PH_MID    = 4'd5,
        PH_GAP    = 4'd6,
        PH_VERB   = 4'd7,
        PH_TRAIL  = 4'd8,
        PH_BLANK  = 4'd9
    } phase_t;

    localparam logic [18:0] ALL_NAMES = '1;

    phase_t      phase_reg, phase_next;
    logic        held_reg, held_next;          // held byte is always a space
    logic [4:0]  pc_reg, pc_next;
    logic [18:0] match_reg, match_next;
    logic [2:0]  pos_reg, pos_next;
    logic        ended_reg, ended_next;
    logic        open_reg, open_next;
    logic [1:0]  cnt;
    logic [4:0]  code;
    logic        verb;

    // Knock out names that disagree with this byte, case folded
    function automatic logic [18:0] match_step(logic [18:0] mb, logic [2:0] pos,
                                               logic [7:0] b);
        logic [7:0]  f;
        logic [7:0]  c;
        logic [18:0] m;
        m = mb;
        f = (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
        for (int k = 0; k < irc_tok_pkg::NAME_COUNT; k++) begin
            c = irc_tok_pkg::name_char(k, pos);
            if (c == irc_tok_pkg::CHR_NUL || c != f) begin
                m[k] = 1'b0;
            end
        end
        return m;
    endfunction

    // Step for one byte
    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        pc_next    = pc_reg;
        match_next = match_reg;
        pos_next   = pos_reg;
        ended_next = ended_reg;
        open_next  = open_reg;
        bundle     = '0;
        cnt        = 2'd0;
        code       = 5'(irc_tok_pkg::NAME_COUNT);
        verb       = 1'b0;

        if (!ended_next) begin
            if (byte_in == irc_tok_pkg::CHR_NUL) begin
                // zero byte ends the string
                if (held_next) begin
                    held_next = 1'b0;
                    bundle.slot[cnt] = irc_tok_pkg::tok_res(irc_tok_pkg::KIND_MIDDLE,
                        irc_tok_pkg::CHR_SPACE, pc_next - 5'd1, !open_next);
                    open_next = 1'b1;
                    cnt = cnt + 2'd1;
                end
                ended_next = 1'b1;
                if (phase_next == PH_START) begin
                    phase_next = PH_BLANK;
                end
            end else begin
                case (phase_next)
                    PH_START: begin
                        open_next = 1'b0;
                        if (byte_in == irc_tok_pkg::CHR_LF) begin
                            phase_next = PH_BLANK;
                            ended_next = 1'b1;
                        end else if (byte_in == irc_tok_pkg::CHR_COLON) begin
                            phase_next = PH_ORIGIN;
                        end else if (byte_in == irc_tok_pkg::CHR_SPACE) begin
                            phase_next = PH_MSG;
                            pc_next    = 5'd1;
                        end else begin
                            phase_next = PH_CMD_B;
                            match_next = match_step(match_next, pos_next, byte_in);
                            if (pos_next < 3'd7) pos_next = pos_next + 3'd1;
                            bundle.slot[cnt] = irc_tok_pkg::tok_res(
                                irc_tok_pkg::KIND_COMMAND, byte_in, 5'd0, !open_next);
                            open_next = 1'b1;
                            cnt = cnt + 2'd1;
                        end
                    end
                    PH_ORIGIN: begin
                        if (byte_in == irc_tok_pkg::CHR_SPACE) begin
                            phase_next = PH_CMD_A;
                            open_next  = 1'b0;
                        end else begin
                            bundle.slot[cnt] = irc_tok_pkg::tok_res(
                                irc_tok_pkg::KIND_ORIGIN, byte_in, 5'd0, !open_next);
                            open_next = 1'b1;
                            cnt = cnt + 2'd1;
                        end
                    end
                    PH_CMD_A, PH_CMD_B: begin
                        if (byte_in == irc_tok_pkg::CHR_SPACE) begin
                            phase_next = PH_MSG;
                            pc_next    = 5'd1;
                            open_next  = 1'b0;
                        end else begin
                            match_next = match_step(match_next, pos_next, byte_in);
                            if (pos_next < 3'd7) pos_next = pos_next + 3'd1;
                            bundle.slot[cnt] = irc_tok_pkg::tok_res(
                                irc_tok_pkg::KIND_COMMAND, byte_in, 5'd0, !open_next);
                            open_next = 1'b1;
                            cnt = cnt + 2'd1;
                        end
                    end
                    PH_MSG: begin
                        open_next = 1'b0;
                        verb = (pc_next >= 5'(irc_tok_pkg::MAX_MIDDLE_PARAMS));
                        if (byte_in == irc_tok_pkg::CHR_COLON) begin
                            phase_next = PH_TRAIL;
                        end else if (byte_in == irc_tok_pkg::CHR_SPACE) begin
                            if (verb) begin
                                phase_next = PH_VERB;
                                held_next  = 1'b1;
                            end else begin
                                phase_next = PH_GAP;
                            end
                        end else begin
                            phase_next = verb ? PH_VERB : PH_MID;
                            bundle.slot[cnt] = irc_tok_pkg::tok_res(
                                irc_tok_pkg::KIND_MIDDLE, byte_in, pc_next - 5'd1,
                                !open_next);
                            open_next = 1'b1;
                            cnt = cnt + 2'd1;
                        end
                    end
                    PH_MID: begin
                        if (byte_in == irc_tok_pkg::CHR_SPACE) begin
                            phase_next = PH_GAP;
                        end else begin
                            bundle.slot[cnt] = irc_tok_pkg::tok_res(
                                irc_tok_pkg::KIND_MIDDLE, byte_in, pc_next - 5'd1,
                                !open_next);
                            open_next = 1'b1;
                            cnt = cnt + 2'd1;
                        end
                    end
                    PH_GAP: begin
                        if (byte_in == irc_tok_pkg::CHR_COLON) begin
                            pc_next    = pc_next + 5'd1;
                            open_next  = 1'b0;
                            phase_next = PH_TRAIL;
                        end else if (byte_in != irc_tok_pkg::CHR_SPACE) begin
                            pc_next    = pc_next + 5'd1;
                            open_next  = 1'b0;
                            verb = (pc_next >= 5'(irc_tok_pkg::MAX_MIDDLE_PARAMS));
                            phase_next = verb ? PH_VERB : PH_MID;
                            bundle.slot[cnt] = irc_tok_pkg::tok_res(
                                irc_tok_pkg::KIND_MIDDLE, byte_in, pc_next - 5'd1,
                                !open_next);
                            open_next = 1'b1;
                            cnt = cnt + 2'd1;
                        end
                    end
                    PH_VERB: begin
                        if (byte_in == irc_tok_pkg::CHR_COLON && held_next) begin
                            // a held space then ':' opens the trailing parameter
                            held_next  = 1'b0;
                            pc_next    = pc_next + 5'd1;
                            open_next  = 1'b0;
                            phase_next = PH_TRAIL;
                        end else begin
                            if (held_next) begin
                                held_next = 1'b0;
                                bundle.slot[cnt] = irc_tok_pkg::tok_res(
                                    irc_tok_pkg::KIND_MIDDLE, irc_tok_pkg::CHR_SPACE,
                                    pc_next - 5'd1, !open_next);
                                open_next = 1'b1;
                                cnt = cnt + 2'd1;
                            end
                            if (byte_in == irc_tok_pkg::CHR_SPACE) begin
                                held_next = 1'b1;
                            end else begin
                                bundle.slot[cnt] = irc_tok_pkg::tok_res(
                                    irc_tok_pkg::KIND_MIDDLE, byte_in, pc_next - 5'd1,
                                    !open_next);
                                open_next = 1'b1;
                                cnt = cnt + 2'd1;
                            end
                        end
                    end
                    PH_TRAIL: begin
                        bundle.slot[cnt] = irc_tok_pkg::tok_res(irc_tok_pkg::KIND_TRAIL,
                            byte_in, pc_next - 5'd1, !open_next);
                        open_next = 1'b1;
                        cnt = cnt + 2'd1;
                    end
                    default: begin
                        ended_next = 1'b1;
                    end
                endcase
            end
        end

        // Line end: flush a held space, append the summary, back to line start
        if (line_end) begin
            if (held_next) begin
                held_next = 1'b0;
                bundle.slot[cnt] = irc_tok_pkg::tok_res(irc_tok_pkg::KIND_MIDDLE,
                    irc_tok_pkg::CHR_SPACE, pc_next - 5'd1, !open_next);
                cnt = cnt + 2'd1;
            end
            for (int k = irc_tok_pkg::NAME_COUNT - 1; k >= 0; k--) begin
                if (match_next[k] && irc_tok_pkg::name_char(k, pos_next) ==
                        irc_tok_pkg::CHR_NUL) begin
                    code = 5'(k);
                end
            end
            bundle.slot[cnt]      = '0;
            bundle.slot[cnt].kind = irc_tok_pkg::KIND_SUMMARY;
            if (phase_next == PH_BLANK) begin
                bundle.slot[cnt].line_status  = irc_tok_pkg::STATUS_BLANK;
                bundle.slot[cnt].command_code = 5'(irc_tok_pkg::NAME_COUNT);
            end else if (phase_next == PH_START || phase_next == PH_ORIGIN ||
                         phase_next == PH_CMD_B) begin
                bundle.slot[cnt].line_status  = irc_tok_pkg::STATUS_NO_CMD;
                bundle.slot[cnt].command_code = 5'(irc_tok_pkg::NAME_COUNT);
            end else begin
                bundle.slot[cnt].line_status  = irc_tok_pkg::STATUS_GOOD;
                bundle.slot[cnt].command_code = code;
                bundle.slot[cnt].param_total  = (phase_next == PH_CMD_A) ? 5'd0 : pc_next;
            end
            cnt        = cnt + 2'd1;
            phase_next = PH_START;
            held_next  = 1'b0;
            pc_next    = 5'd0;
            match_next = ALL_NAMES;
            pos_next   = 3'd0;
            ended_next = 1'b0;
            open_next  = 1'b0;
        end

        if (cnt != 2'd0) begin
            bundle.slot[cnt - 2'd1].run_last = 1'b1;
        end
        bundle.count = cnt;
    end

    // Line state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            held_reg  <= 1'b0;
            pc_reg    <= 5'd0;
            match_reg <= ALL_NAMES;
            pos_reg   <= 3'd0;
            ended_reg <= 1'b0;
            open_reg  <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            pc_reg    <= pc_next;
            match_reg <= match_next;
            pos_reg   <= pos_next;
            ended_reg <= ended_next;
            open_reg  <= open_next;
        end
    end

endmodule

[rtl/irc_tok_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_tok_emit
// Result register: holds the bundle of one byte and hands its results out
// one transaction per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module irc_tok_emit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  irc_tok_pkg::bundle_t bundle,
    output logic                 free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output irc_tok_pkg::res_t    m_res
);

    irc_tok_pkg::res_t [irc_tok_pkg::RESULTS_MAX-1:0] slot_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign m_valid = (cnt_reg != 2'd0);
    assign m_res   = slot_reg[0];
    assign pop     = m_valid && m_ready;
    // Free when nothing waits or the last waiting result leaves in this cycle
    assign free    = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);

    // Count of results still to deliver
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= bundle.count;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Result slots, shifted towards the output
    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= bundle.slot;
        end else if (pop) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

`ifndef NO_ASSERTIONS
    // A bundle never lands on results still waiting
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && m_ready)))
        else $error("bundle loaded over waiting results");

    // The final waiting result closes the run
    a_last_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && cnt_reg == 2'd1) |-> m_res.run_last)
        else $error("last result of a byte lacks run_last");

    // Earlier results of a run do not close it
    a_not_early: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg > 2'd1) |-> !m_res.run_last)
        else $error("run_last before the end of a run");

    // Draining the last result with nothing loaded leaves the output empty
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && cnt_reg == 2'd1 && !load) |=> !m_valid)
        else $error("output still valid after draining");
`endif

endmodule

[rtl/irc_line_tokenizer_top.sv]
`timescale 1ns / 1ps
// Path: a byte is held in the input register, then its bundle in the result register.
// Throughput: one byte per cycle while each byte gives at most one result and m_ready
//   is high; a byte giving k results (k up to 3) holds the single result register until all k leave.
// Reset: aresetn is synchronous, active low; the line state returns to line start
//   and both the input and result registers are emptied.
// ----------------------------------------------------------------------------
// irc_line_tokenizer_top
// IRC line tokenizer: input register, single-pass parse step and result
// register with one transaction per cycle on each side when nothing stalls.
// ----------------------------------------------------------------------------
module irc_line_tokenizer_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       s_line_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_data_byte,
    output logic [4:0] m_param_index,
    output logic       m_token_first,
    output logic [4:0] m_command_code,
    output logic [4:0] m_param_total,
    output logic [1:0] m_line_status,
    output logic       m_run_last
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_end_reg;
    logic                 free;
    logic                 fire;
    irc_tok_pkg::bundle_t bundle;
    irc_tok_pkg::res_t    m_res;

    assign fire    = in_valid_reg && free;
    assign s_ready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_in;
            in_end_reg  <= s_line_end;
        end
    end

    irc_tok_parse u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .byte_in  (in_byte_reg),
        .line_end (in_end_reg),
        .bundle   (bundle)
    );

    irc_tok_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (fire),
        .bundle  (bundle),
        .free    (free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    // Result fields
    assign m_kind         = m_res.kind;
    assign m_data_byte    = m_res.data_byte;
    assign m_param_index  = m_res.param_index;
    assign m_token_first  = m_res.token_first;
    assign m_command_code = m_res.command_code;
    assign m_param_total  = m_res.param_total;
    assign m_line_status  = m_res.line_status;
    assign m_run_last     = m_res.run_last;

endmodule
